@@ rtl/core/crbp_pkg.sv @@
`default_nettype none

package crbp_pkg;

	localparam int OFF_W      = 31;
	localparam int MINNZ_W    = 21;
	localparam int ROWS_W     = 11;
	localparam int IDX_W      = 6;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_USER_W = 2;
	localparam int ADDR_W     = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [MINNZ_W-1:0] MIN_NZ_RESET   = 21'd256;
	localparam logic [ROWS_W-1:0]  MAX_ROWS_RESET = 11'd256;

	typedef enum logic {
		REG_MIN_NZ   = 1'b0,
		REG_MAX_ROWS = 1'b1
	} reg_idx_t;

	typedef enum logic {
		KIND_APPEND = 1'b0,
		KIND_ENTRY  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		CMD_SINGLE = 2'd0,
		CMD_PAIR   = 2'd1,
		CMD_SPLIT  = 2'd2
	} cmd_mode_t;

	typedef enum logic [1:0] {
		F_IDLE = 2'd0,
		F_EVAL = 2'd1,
		F_DIV  = 2'd2,
		F_PUSH = 2'd3
	} front_state_t;

	typedef struct packed {
		logic [MINNZ_W-1:0] min_nz;
		logic [ROWS_W-1:0]  max_rows;
	} cfg_t;

	typedef struct packed {
		cmd_mode_t        mode;
		logic [OFF_W-1:0] row;
		logic [OFF_W-1:0] base;
		logic             extra;
		logic             trunc;
		logic [IDX_W-1:0] last_idx;
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/csr_row_block_partitioner.sv @@
`default_nettype none

// CSR row-block partitioner. Each request on the slave stream is one CSR row-end
// offset (tlast marks the final row of a matrix); the master stream carries the
// block start rows and first-block-of-row entry writes that the row causes, tlast
// on the last of them. A row holding at least twice min_nonzeros_per_block runs
// the serial divider, one quotient bit a cycle. The back end sends one result a
// cycle while the master side takes them, with a gap between rows, and a split
// run gives at most MAX_SPLIT_RESULTS results. A small command queue lets the
// front keep taking rows while results wait on the master side. Registers sit on
// the APB port at byte addresses 0 (min_nonzeros_per_block) and 4 (the row limit
// per block); write them only while idle.
module csr_row_block_partitioner #(
	parameter int MAX_SPLIT_RESULTS = 64,
	parameter int CMD_QUEUE_DEPTH   = 2
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// [30:0] row_end_offset, [31] zero
	input  wire logic [crbp_pkg::IN_DATA_W-1:0]    s_tdata,
	input  wire logic                              s_tlast,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [30:0] target_row, [61:31] entry_value, [63:62] zero
	output logic [crbp_pkg::OUT_DATA_W-1:0]        m_tdata,
	// [0] kind, [1] truncated
	output logic [crbp_pkg::OUT_USER_W-1:0]        m_tuser,
	output logic                                   m_tlast,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [crbp_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [crbp_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [crbp_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                   pready
);

	crbp_pkg::cfg_t    cfg_q;
	crbp_pkg::reg_idx_t reg_sel;
	logic              cfg_wr;

	logic                                  push;
	crbp_pkg::cmd_t                        push_cmd;
	logic                                  full;
	logic                                  pop;
	crbp_pkg::cmd_t                        pop_cmd;
	logic                                  empty;
	logic                                  div_start;
	logic [crbp_pkg::OFF_W-1:0]            div_dividend;
	logic [crbp_pkg::MINNZ_W-1:0]          div_divisor;
	logic                                  div_done;
	logic [crbp_pkg::OFF_W-1:0]            div_quotient;

	assign pready  = 1'b1;
	assign reg_sel = crbp_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_nz   <= crbp_pkg::MIN_NZ_RESET;
			cfg_q.max_rows <= crbp_pkg::MAX_ROWS_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				crbp_pkg::REG_MIN_NZ:   cfg_q.min_nz   <= pwdata[crbp_pkg::MINNZ_W-1:0];
				crbp_pkg::REG_MAX_ROWS: cfg_q.max_rows <= pwdata[crbp_pkg::ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			crbp_pkg::REG_MIN_NZ:
				prdata = crbp_pkg::APB_DATA_W'(cfg_q.min_nz);
			crbp_pkg::REG_MAX_ROWS:
				prdata = crbp_pkg::APB_DATA_W'(cfg_q.max_rows);
			default: prdata = '0;
		endcase
	end

	crbp_front #(
		.MAX_SPLIT_RESULTS(MAX_SPLIT_RESULTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.cfg          (cfg_q),
		.push         (push),
		.push_cmd     (push_cmd),
		.full         (full),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_quotient (div_quotient)
	);

	crbp_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	crbp_cmd_fifo #(
		.DEPTH(CMD_QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_cmd),
		.empty     (empty)
	);

	crbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.pop      (pop),
		.cmd      (pop_cmd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	a_min_floor: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> div_divisor != '0)
		else $error("divider started with a zero divisor");
`endif

endmodule

`default_nettype wire

@@ rtl/core/crbp_divider.sv @@
`default_nettype none

module crbp_divider (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [crbp_pkg::OFF_W-1:0]    dividend,
	input  wire logic [crbp_pkg::MINNZ_W-1:0]  divisor,
	output logic                               done,
	output logic [crbp_pkg::OFF_W-1:0]         quotient
);

	localparam int CNT_W = $clog2(crbp_pkg::OFF_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [crbp_pkg::OFF_W-1:0]    quo_q;
	logic [crbp_pkg::MINNZ_W-1:0]  rem_q;
	logic [crbp_pkg::MINNZ_W-1:0]  div_q;
	logic [crbp_pkg::MINNZ_W:0]    trial;
	logic                          ge;

	// One quotient bit per cycle; the dividend shifts out as the quotient shifts in.
	assign trial = {rem_q, quo_q[crbp_pkg::OFF_W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(crbp_pkg::OFF_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[crbp_pkg::OFF_W-2:0], ge};
			rem_q <= ge ? crbp_pkg::MINNZ_W'(trial - {1'b0, div_q})
			            : trial[crbp_pkg::MINNZ_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_done_after_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == '0 && !start) |=> (done_q && !busy_q))
		else $error("divider did not finish after its last step");
`endif

endmodule

`default_nettype wire

@@ rtl/core/crbp_cmd_fifo.sv @@
`default_nettype none

module crbp_cmd_fifo #(
	parameter int DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire crbp_pkg::cmd_t push_data,
	output logic                full,
	input  wire logic           pop,
	output crbp_pkg::cmd_t      pop_data,
	output logic                empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	crbp_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data = mem_q[rd_ptr_q];

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command popped from an empty queue");
`endif

endmodule

`default_nettype wire

@@ rtl/core/crbp_front.sv @@
`default_nettype none

module crbp_front #(
	parameter int MAX_SPLIT_RESULTS = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [crbp_pkg::IN_DATA_W-1:0]  s_tdata,
	input  wire logic                            s_tlast,
	input  wire crbp_pkg::cfg_t                  cfg,
	output logic                                 push,
	output crbp_pkg::cmd_t                       push_cmd,
	input  wire logic                            full,
	output logic                                 div_start,
	output logic [crbp_pkg::OFF_W-1:0]           div_dividend,
	output logic [crbp_pkg::MINNZ_W-1:0]         div_divisor,
	input  wire logic                            div_done,
	input  wire logic [crbp_pkg::OFF_W-1:0]      div_quotient
);

	localparam int W  = crbp_pkg::OFF_W;
	localparam int MW = crbp_pkg::MINNZ_W;
	localparam int IW = crbp_pkg::IDX_W;
	localparam logic [W:0] MaxRes = (W + 1)'(MAX_SPLIT_RESULTS);

	crbp_pkg::front_state_t state_q, state_next;

	logic [W-1:0]                  off_q;
	logic                          last_q;
	logic [W-1:0]                  prev_offset_q;
	logic [W-1:0]                  nz_accum_q;
	logic [crbp_pkg::ROWS_W-1:0]   rows_q;
	logic [W-1:0]                  row_cnt_q;
	logic [W-1:0]                  block_cnt_q;
	logic [W-1:0]                  multi_q;

	logic [MW-1:0]                 minv;
	logic [W-1:0]                  row;
	logic [W-1:0]                  cur;
	logic [W:0]                    acc_sum;
	logic [W-1:0]                  acc;
	logic [crbp_pkg::ROWS_W-1:0]   rows_inc;
	logic                          close_nz;
	logic                          long_row;
	logic                          close_rows;
	logic                          needs_push;
	logic                          extra;
	logic [W:0]                    total;
	logic                          trunc;
	logic [IW-1:0]                 split_last;
	logic [W-1:0]                  bc_next;
	logic                          commit;
	logic                          accept;

	assign minv     = (cfg.min_nz == '0) ? MW'(1) : cfg.min_nz;
	assign row      = row_cnt_q + 1'b1;
	assign cur      = (off_q >= prev_offset_q) ? off_q - prev_offset_q : '0;
	assign acc_sum  = {1'b0, nz_accum_q} + {1'b0, cur};
	assign acc      = acc_sum[W] ? '1 : acc_sum[W-1:0];
	assign rows_inc = (rows_q != '1) ? rows_q + 1'b1 : rows_q;

	// A row of at least twice the minimum is split, which needs its quotient.
	assign close_nz   = acc >= W'(minv);
	assign long_row   = close_nz && (cur >= W'({minv, 1'b0}));
	assign close_rows = (rows_inc >= cfg.max_rows) || last_q;
	assign needs_push = close_nz || close_rows;
	assign extra      = nz_accum_q != '0;

	assign total      = {1'b0, multi_q} + (W + 1)'(extra) + (W + 1)'(1);
	assign trunc      = total > MaxRes;
	assign split_last = trunc ? IW'(MAX_SPLIT_RESULTS - 1) : IW'(multi_q + W'(extra));

	always_comb begin
		if (long_row) begin
			bc_next = block_cnt_q + multi_q + W'(extra);
		end else begin
			bc_next = block_cnt_q + 1'b1;
		end
	end

	always_comb begin
		push_cmd.row      = row;
		push_cmd.base     = block_cnt_q;
		push_cmd.extra    = extra;
		push_cmd.trunc    = long_row && trunc;
		if (long_row) begin
			push_cmd.mode     = crbp_pkg::CMD_SPLIT;
			push_cmd.last_idx = split_last;
		end else if (close_nz) begin
			push_cmd.mode     = crbp_pkg::CMD_SINGLE;
			push_cmd.last_idx = '0;
		end else begin
			push_cmd.mode     = crbp_pkg::CMD_PAIR;
			push_cmd.last_idx = IW'(1);
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			crbp_pkg::F_IDLE: begin
				if (s_tvalid) begin
					state_next = crbp_pkg::F_EVAL;
				end
			end
			crbp_pkg::F_EVAL: begin
				if (long_row) begin
					state_next = crbp_pkg::F_DIV;
				end else if (!needs_push || !full) begin
					state_next = crbp_pkg::F_IDLE;
				end
			end
			crbp_pkg::F_DIV: begin
				if (div_done) begin
					state_next = crbp_pkg::F_PUSH;
				end
			end
			crbp_pkg::F_PUSH: begin
				if (!full) begin
					state_next = crbp_pkg::F_IDLE;
				end
			end
			default: state_next = crbp_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		commit    = 1'b0;
		case (state_q)
			crbp_pkg::F_IDLE: s_tready = 1'b1;
			crbp_pkg::F_EVAL: begin
				div_start = long_row;
				commit    = !long_row && (!needs_push || !full);
			end
			crbp_pkg::F_PUSH: commit = !full;
			default: ;
		endcase
	end

	assign push         = commit && needs_push;
	assign accept       = s_tvalid && s_tready;
	assign div_dividend = cur;
	assign div_divisor  = minv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= crbp_pkg::F_IDLE;
			prev_offset_q <= '0;
			nz_accum_q    <= '0;
			rows_q        <= '0;
			row_cnt_q     <= '0;
			block_cnt_q   <= '0;
		end else begin
			state_q <= state_next;
			if (commit) begin
				if (last_q) begin
					prev_offset_q <= '0;
					row_cnt_q     <= '0;
					block_cnt_q   <= '0;
				end else begin
					prev_offset_q <= off_q;
					row_cnt_q     <= row;
					block_cnt_q   <= needs_push ? bc_next : block_cnt_q;
				end
				nz_accum_q <= needs_push ? '0 : acc;
				rows_q     <= needs_push ? '0 : rows_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			off_q  <= s_tdata[W-1:0];
			last_q <= s_tlast;
		end
		if (state_q == crbp_pkg::F_DIV && div_done) begin
			multi_q <= div_quotient;
		end
	end

`ifndef SYNTHESIS
	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == crbp_pkg::F_EVAL)
		else $error("accepted row was not evaluated next");
	a_push_only_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("front pushed a command without room");
`endif

endmodule

`default_nettype wire

@@ rtl/core/crbp_back.sv @@
`default_nettype none

module crbp_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              empty,
	output logic                                   pop,
	input  wire crbp_pkg::cmd_t                    cmd,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [crbp_pkg::OUT_DATA_W-1:0]        m_tdata,
	output logic [crbp_pkg::OUT_USER_W-1:0]        m_tuser,
	output logic                                   m_tlast
);

	localparam int W  = crbp_pkg::OFF_W;
	localparam int IW = crbp_pkg::IDX_W;

	logic             busy_q;
	crbp_pkg::cmd_t   cmd_q;
	logic [IW-1:0]    j_q;
	logic             out_valid_q;
	logic [crbp_pkg::OUT_DATA_W-1:0] out_data_q;
	logic [crbp_pkg::OUT_USER_W-1:0] out_user_q;
	logic             out_last_q;

	logic             load;
	logic             is_end;
	logic [W-1:0]     prow;
	logic [W-1:0]     base_inc;
	logic [W-1:0]     base_extra;
	crbp_pkg::kind_t  kind;
	logic [W-1:0]     target_row;
	logic [W-1:0]     entry_value;

	assign load       = busy_q && (!out_valid_q || m_tready);
	assign pop        = !busy_q && !empty;
	assign is_end     = j_q == cmd_q.last_idx;
	assign prow       = cmd_q.row - 1'b1;
	assign base_inc   = cmd_q.base + 1'b1;
	assign base_extra = cmd_q.base + W'(cmd_q.extra);

	always_comb begin
		kind        = crbp_pkg::KIND_APPEND;
		target_row  = cmd_q.row;
		entry_value = base_inc;
		case (cmd_q.mode)
			crbp_pkg::CMD_SINGLE: ;
			crbp_pkg::CMD_PAIR: begin
				if (j_q != '0) begin
					kind        = crbp_pkg::KIND_ENTRY;
					entry_value = {base_inc[W-2:0], 1'b0};
				end
			end
			crbp_pkg::CMD_SPLIT: begin
				// The entry write comes first, or second after the append that closes
				// a block the row joined part way.
				if (j_q == IW'(cmd_q.extra)) begin
					kind        = crbp_pkg::KIND_ENTRY;
					target_row  = prow;
					entry_value = {base_extra[W-2:0], 1'b1};
				end else begin
					target_row  = (is_end && !cmd_q.trunc) ? cmd_q.row : prow;
					entry_value = (j_q == '0) ? base_inc : cmd_q.base + W'(j_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (load && is_end) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd;
			j_q   <= '0;
		end else if (load) begin
			j_q <= j_q + 1'b1;
		end
		if (load) begin
			out_data_q <= {{(crbp_pkg::OUT_DATA_W - 2 * W){1'b0}}, entry_value, target_row};
			out_user_q <= {cmd_q.trunc, kind};
			out_last_q <= is_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_index_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> j_q <= cmd_q.last_idx)
		else $error("result index ran past the end of its run");
	a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !pop)
		else $error("command taken while one is still being emitted");
`endif

endmodule

`default_nettype wire
